FILE: rtl/gwb_pkg.sv
// Package: shared types, constants and helpers of the gray-world gain block.
`timescale 1ns / 1ps
`default_nettype none
package gwb_pkg;

    localparam int CH_W     = 16;
    localparam int LUMA_W   = 16;
    localparam int SAT_W    = 8;
    localparam int SKIP_W   = 14;
    localparam int GAIN_W   = 20;
    localparam int USED_W   = 14;
    localparam int WGT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_MAX_PAXELS     = 4096;
    localparam int DEF_GAIN_FRAC_BITS = 12;

    localparam logic [SAT_W-1:0]  RST_SAT_LIMIT   = 8'd141;
    localparam logic [LUMA_W-1:0] RST_LUMA_MIN    = 16'd4;
    localparam logic [LUMA_W-1:0] RST_LUMA_MAX    = 16'd200;
    localparam logic [SKIP_W-1:0] RST_SKIP_PAXELS = 14'd0;

    localparam logic [SAT_W:0]    SAT_SCALE = 9'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_MAX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_PAXELS = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green_r;
        logic [CH_W-1:0]   green_b;
        logic [CH_W-1:0]   blue;
        logic [LUMA_W-1:0] luma;
        logic              last_paxel;
    } t_paxel;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_r;
        logic [GAIN_W-1:0] gain_gr;
        logic [GAIN_W-1:0] gain_gb;
        logic [GAIN_W-1:0] gain_b;
        logic              gains_valid;
        logic [USED_W-1:0] paxels_used;
    } t_gains;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [2:0] {
        B_IDLE,
        B_YMUL,
        B_DINIT,
        B_DIV,
        B_OUT
    } t_bstate;

    // Q0.16 luma weight of channel k: R, Gr, Gb, B
    function automatic logic [WGT_W-1:0] weight_of(input logic [1:0] k);
        logic [WGT_W-1:0] w;
        unique case (k)
            2'd0:    w = 16'd19595;
            2'd1:    w = 16'd19235;
            2'd2:    w = 16'd19235;
            default: w = 16'd7471;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/gwb_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
`default_nettype none
interface gwb_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/gwb_front.sv
// Front end: configuration registers, paxel screening and per-frame accumulation.
`timescale 1ns / 1ps
`default_nettype none
module gwb_front #(
    parameter int MAX_PAXELS = gwb_pkg::DEF_MAX_PAXELS,
    parameter int CNT_W      = $clog2(MAX_PAXELS + 1),
    parameter int SUM_W      = gwb_pkg::CH_W + CNT_W,
    parameter int ENT_W      = 4 * SUM_W + CNT_W
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gwb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [gwb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    gwb_stream_if.sink                           i_pax,
    input  wire gwb_pkg::t_queue_status          i_q_status,
    output logic                                 o_push,
    output logic [ENT_W-1:0]                     o_push_data
);

    logic [gwb_pkg::SAT_W-1:0]  r_sat_limit;
    logic [gwb_pkg::LUMA_W-1:0] r_luma_min;
    logic [gwb_pkg::LUMA_W-1:0] r_luma_max;
    logic [gwb_pkg::SKIP_W-1:0] r_skip;

    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_sum [4];

    logic [gwb_pkg::CH_W-1:0] ch [4];
    logic [gwb_pkg::CH_W-1:0] hi, lo, delta;
    logic [24:0]              lhs, rhs;
    logic                     in_win, sat_ok, luma_ok, take, acc;
    logic [CNT_W-1:0]         n_cnt, n_pos;
    logic [SUM_W-1:0]         n_sum [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_limit <= gwb_pkg::RST_SAT_LIMIT;
            r_luma_min  <= gwb_pkg::RST_LUMA_MIN;
            r_luma_max  <= gwb_pkg::RST_LUMA_MAX;
            r_skip      <= gwb_pkg::RST_SKIP_PAXELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gwb_pkg::CFG_SAT_LIMIT: r_sat_limit <= i_cfg_data[gwb_pkg::SAT_W-1:0];
                gwb_pkg::CFG_LUMA_MIN:  r_luma_min  <= i_cfg_data;
                gwb_pkg::CFG_LUMA_MAX:  r_luma_max  <= i_cfg_data;
                default:                r_skip      <= i_cfg_data[gwb_pkg::SKIP_W-1:0];
            endcase
        end
    end

    assign ch[0] = i_pax.data.red;
    assign ch[1] = i_pax.data.green_r;
    assign ch[2] = i_pax.data.green_b;
    assign ch[3] = i_pax.data.blue;

    always_comb begin
        logic [gwb_pkg::CH_W-1:0] h01, h23, l01, l23;
        h01   = (ch[0] > ch[1]) ? ch[0] : ch[1];
        h23   = (ch[2] > ch[3]) ? ch[2] : ch[3];
        l01   = (ch[0] < ch[1]) ? ch[0] : ch[1];
        l23   = (ch[2] < ch[3]) ? ch[2] : ch[3];
        hi    = (h01 > h23) ? h01 : h23;
        lo    = (l01 < l23) ? l01 : l23;
        delta = hi - lo;
    end

    // floor(delta*255/hi) <= limit  <=>  delta*255 < (limit+1)*hi
    assign lhs     = 25'(delta) * 25'(gwb_pkg::SAT_SCALE);
    assign rhs     = 25'({1'b0, r_sat_limit} + 9'd1) * 25'(hi);
    assign sat_ok  = (delta == '0) || (lhs < rhs);
    assign luma_ok = (i_pax.data.luma >= r_luma_min) && (i_pax.data.luma <= r_luma_max);
    assign in_win  = (32'(r_pos) >= 32'(r_skip)) && (32'(r_pos) < MAX_PAXELS);
    assign take    = in_win && sat_ok && luma_ok;

    assign i_pax.ready = !i_q_status.full;
    assign acc         = i_pax.valid && i_pax.ready;

    always_comb begin
        n_cnt = take ? r_cnt + CNT_W'(1) : r_cnt;
        n_pos = (32'(r_pos) < MAX_PAXELS) ? r_pos + CNT_W'(1) : r_pos;
        for (int k = 0; k < 4; k++) begin
            n_sum[k] = take ? r_sum[k] + SUM_W'(ch[k]) : r_sum[k];
        end
    end

    assign o_push      = acc && i_pax.data.last_paxel;
    assign o_push_data = {n_cnt, n_sum[3], n_sum[2], n_sum[1], n_sum[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cnt <= '0;
            for (int k = 0; k < 4; k++) r_sum[k] <= '0;
        end else if (acc) begin
            // clear the frame state once the frame-end item is queued
            if (i_pax.data.last_paxel) begin
                r_pos <= '0;
                r_cnt <= '0;
                for (int k = 0; k < 4; k++) r_sum[k] <= '0;
            end else begin
                r_pos <= n_pos;
                r_cnt <= n_cnt;
                for (int k = 0; k < 4; k++) r_sum[k] <= n_sum[k];
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/gwb_queue.sv
// Two-entry queue of frame totals between front end and gain engine.
`timescale 1ns / 1ps
`default_nettype none
module gwb_queue #(
    parameter int ENT_W = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire logic [ENT_W-1:0]       i_push_data,
    input  wire logic                   i_pop,
    output logic [ENT_W-1:0]            o_pop_data,
    output gwb_pkg::t_queue_status      o_status
);

    logic [ENT_W-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);
    assign o_pop_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/gwb_back.sv
// Gain engine: weighted luma, bit-serial division per channel and result register.
`timescale 1ns / 1ps
`default_nettype none
module gwb_back #(
    parameter int MAX_PAXELS     = gwb_pkg::DEF_MAX_PAXELS,
    parameter int GAIN_FRAC_BITS = gwb_pkg::DEF_GAIN_FRAC_BITS,
    parameter int CNT_W          = $clog2(MAX_PAXELS + 1),
    parameter int SUM_W          = gwb_pkg::CH_W + CNT_W,
    parameter int ENT_W          = 4 * SUM_W + CNT_W
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire gwb_pkg::t_queue_status i_q_status,
    input  wire logic [ENT_W-1:0]       i_pop_data,
    output logic                        o_pop,
    gwb_stream_if.source                o_gain
);

    localparam int PROD_W = SUM_W + gwb_pkg::WGT_W;
    localparam int Y_W    = PROD_W + 2;
    localparam int CW     = SUM_W + gwb_pkg::WGT_W + gwb_pkg::GAIN_W + 1;
    localparam int BIT_W  = $clog2(gwb_pkg::GAIN_W + 1);

    gwb_pkg::t_bstate r_state, n_state;

    logic [ENT_W-1:0]          r_ent;
    logic [PROD_W-1:0]         r_prod;
    logic [Y_W-1:0]            r_y;
    logic [2:0]                r_step;
    logic [1:0]                r_ch;
    logic [BIT_W-1:0]          r_bit;
    logic [CW-1:0]             r_rem, r_den;
    logic [gwb_pkg::GAIN_W-1:0] r_q;
    logic [gwb_pkg::GAIN_W-1:0] r_gain [4];
    logic                      r_gvalid;
    logic [CNT_W-1:0]          r_used;

    logic [SUM_W-1:0]          cur_sum, step_sum;
    logic [CNT_W-1:0]          pop_cnt;
    logic                      ge, last_ch;
    logic [CW-1:0]             diff;
    logic [gwb_pkg::GAIN_W-1:0] n_q;

    assign cur_sum  = r_ent[r_ch * SUM_W +: SUM_W];
    assign step_sum = r_ent[r_step[1:0] * SUM_W +: SUM_W];
    assign pop_cnt  = i_pop_data[4*SUM_W +: CNT_W];
    assign ge       = (r_rem >= r_den);
    assign diff     = r_rem - r_den;
    assign n_q      = {r_q[gwb_pkg::GAIN_W-2:0], ge};
    assign last_ch  = (r_ch == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= gwb_pkg::B_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            gwb_pkg::B_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = (pop_cnt == '0) ? gwb_pkg::B_OUT : gwb_pkg::B_YMUL;
                end
            end
            gwb_pkg::B_YMUL: begin
                if (r_step == 3'd4) n_state = gwb_pkg::B_DINIT;
            end
            gwb_pkg::B_DINIT: begin
                if (cur_sum == '0) n_state = last_ch ? gwb_pkg::B_OUT : gwb_pkg::B_DINIT;
                else               n_state = gwb_pkg::B_DIV;
            end
            gwb_pkg::B_DIV: begin
                if ((r_bit == BIT_W'(gwb_pkg::GAIN_W) && ge) || r_bit == '0) begin
                    n_state = last_ch ? gwb_pkg::B_OUT : gwb_pkg::B_DINIT;
                end
            end
            default: begin
                if (o_gain.ready) n_state = gwb_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            gwb_pkg::B_IDLE: begin
                r_ent    <= i_pop_data;
                r_used   <= pop_cnt;
                r_gvalid <= (pop_cnt != '0);
                r_step   <= 3'd0;
                r_ch     <= 2'd0;
                r_y      <= '0;
                for (int k = 0; k < 4; k++) r_gain[k] <= '0;
            end
            gwb_pkg::B_YMUL: begin
                // multiply one channel while adding the previous product
                if (r_step != 3'd4) begin
                    r_prod <= PROD_W'(gwb_pkg::weight_of(r_step[1:0])) * PROD_W'(step_sum);
                end
                if (r_step != 3'd0) r_y <= r_y + Y_W'(r_prod);
                r_step <= r_step + 3'd1;
            end
            gwb_pkg::B_DINIT: begin
                r_rem <= CW'(r_y) << GAIN_FRAC_BITS;
                r_den <= CW'(cur_sum) << (gwb_pkg::WGT_W + gwb_pkg::GAIN_W);
                r_bit <= BIT_W'(gwb_pkg::GAIN_W);
                r_q   <= '0;
                if (cur_sum == '0) begin
                    r_gain[r_ch] <= gwb_pkg::GAIN_MAX;
                    r_ch         <= r_ch + 2'd1;
                end
            end
            gwb_pkg::B_DIV: begin
                if (ge) r_rem <= diff;
                r_den <= r_den >> 1;
                r_bit <= r_bit - BIT_W'(1);
                if (r_bit == BIT_W'(gwb_pkg::GAIN_W)) begin
                    // quotient needs more than the field holds: saturate
                    if (ge) begin
                        r_gain[r_ch] <= gwb_pkg::GAIN_MAX;
                        r_ch         <= r_ch + 2'd1;
                    end
                end else begin
                    r_q <= n_q;
                    if (r_bit == '0) begin
                        r_gain[r_ch] <= n_q;
                        r_ch         <= r_ch + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_gain.valid            = (r_state == gwb_pkg::B_OUT);
    assign o_gain.data.gain_r      = r_gain[0];
    assign o_gain.data.gain_gr     = r_gain[1];
    assign o_gain.data.gain_gb     = r_gain[2];
    assign o_gain.data.gain_b      = r_gain[3];
    assign o_gain.data.gains_valid = r_gvalid;
    assign o_gain.data.paxels_used = gwb_pkg::USED_W'(r_used);

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_status.empty)
        else $error("pop from empty queue");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gwb_pkg::B_DIV |-> r_bit <= BIT_W'(gwb_pkg::GAIN_W))
        else $error("division step out of range");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gwb_pkg::B_DIV |-> r_den != '0)
        else $error("zero divisor in division");
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_gain.valid && !r_gvalid) |-> (r_used == '0 && r_gain[0] == '0
            && r_gain[1] == '0 && r_gain[2] == '0 && r_gain[3] == '0))
        else $error("empty frame gives nonzero result");
`endif

endmodule
`default_nettype wire

FILE: rtl/gray_world_white_balance_gains_core.sv
// Top level: gray-world white-balance gain block.
// Throughput: one paxel per cycle; the front end stalls only while the frame queue is full.
// With the gain engine idle, the result of a frame-end item comes from the bit-serial gain
// divider; a saturated gain ends its channel early.
// A frame with no accepted paxel skips the luma and division steps of the gain engine.
// Reset (synchronous, active low) restores register defaults and clears sums and queue.
`timescale 1ns / 1ps
`default_nettype none
module gray_world_white_balance_gains_core #(
    parameter int MAX_PAXELS     = gwb_pkg::DEF_MAX_PAXELS,
    parameter int GAIN_FRAC_BITS = gwb_pkg::DEF_GAIN_FRAC_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gwb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gwb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gwb_stream_if.sink                          i_pax,
    gwb_stream_if.source                        o_gain
);

    localparam int CNT_W = $clog2(MAX_PAXELS + 1);
    localparam int SUM_W = gwb_pkg::CH_W + CNT_W;
    localparam int ENT_W = 4 * SUM_W + CNT_W;

    logic                   push, pop;
    logic [ENT_W-1:0]       push_data, pop_data;
    gwb_pkg::t_queue_status q_status;

    gwb_front #(.MAX_PAXELS(MAX_PAXELS), .CNT_W(CNT_W), .SUM_W(SUM_W), .ENT_W(ENT_W)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_pax, .i_q_status(q_status), .o_push(push), .o_push_data(push_data)
    );

    gwb_queue #(.ENT_W(ENT_W)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_push_data(push_data),
        .i_pop(pop), .o_pop_data(pop_data), .o_status(q_status)
    );

    gwb_back #(.MAX_PAXELS(MAX_PAXELS), .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
               .CNT_W(CNT_W), .SUM_W(SUM_W), .ENT_W(ENT_W)) u_back (
        .i_clk, .i_rst_n, .i_q_status(q_status), .i_pop_data(pop_data),
        .o_pop(pop), .o_gain
    );

endmodule
`default_nettype wire
